/* rtl/c_escape_unescaper_defines.svh */
// ---------------------------------------------------------------------------
// C escape unescaper assertion macros
// Shared assertion shorthands for the escape decoder RTL.
// ---------------------------------------------------------------------------
`ifndef C_ESCAPE_UNESCAPER_DEFINES_SVH
`define C_ESCAPE_UNESCAPER_DEFINES_SVH

// Implication checked on every rising edge of clk, idle while reset is held.
`define CESC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define CESC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cesc_pkg.sv */
// ---------------------------------------------------------------------------
// C escape decoder package
// Types, character codes and helper functions for the escape decoder.
// ---------------------------------------------------------------------------
package cesc_pkg;

	localparam int unsigned MAX_LENGTH_DEF = 4096;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 13;

	// Decoder modes.
	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_HEX1 = 2'd2,
		MODE_HEX2 = 2'd3
	} mode_t;

	// Character codes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_X      = 8'h78;

	// Control bytes produced by the single-letter escapes.
	localparam logic [7:0] CTL_BEL = 8'd7;
	localparam logic [7:0] CTL_BS  = 8'd8;
	localparam logic [7:0] CTL_HT  = 8'd9;
	localparam logic [7:0] CTL_LF  = 8'd10;
	localparam logic [7:0] CTL_VT  = 8'd11;
	localparam logic [7:0] CTL_FF  = 8'd12;
	localparam logic [7:0] CTL_CR  = 8'd13;

	// Decoder state carried between bytes.
	typedef struct packed {
		mode_t      mode;
		logic [3:0] nibble;
		logic       err;
	} dec_state_t;

	// Per-byte decode outcome.
	typedef struct packed {
		logic       emit;
		logic [7:0] value;
		logic       ending;
		logic       err;
	} dec_result_t;

	localparam dec_state_t STATE_RESET = '{mode: MODE_TEXT, nibble: 4'd0, err: 1'b0};

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b0, 4'(c - CH_ZERO)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			r = {1'b0, 4'(c - CH_LA + 8'd10)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b0, 4'(c - CH_UA + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LZ) ||
			(c >= CH_UA && c <= CH_UZ);
	endfunction

endpackage

/* rtl/cesc_decode.sv */
// ---------------------------------------------------------------------------
// C escape decoder core
// Combinational next-state and output logic for one source byte.
// ---------------------------------------------------------------------------
module cesc_decode (
	input  logic [7:0]           in_byte,
	input  logic                 last,
	input  cesc_pkg::dec_state_t cur,
	output cesc_pkg::dec_state_t nxt,
	output cesc_pkg::dec_result_t res
);
	import cesc_pkg::*;

	logic [4:0] hex;
	logic       zero;
	logic       emit;
	logic [7:0] value;

	assign hex  = hex_digit(in_byte);
	assign zero = (in_byte == CH_NUL);

	always_comb begin
		nxt   = cur;
		emit  = 1'b0;
		value = '0;
		if (zero) begin
			// A zero byte is a terminator; inside an escape it is an error.
			if (cur.mode != MODE_TEXT) nxt.err = 1'b1;
		end else if (!cur.err) begin
			case (cur.mode)
				MODE_TEXT: begin
					if (in_byte == CH_BSLASH) begin
						nxt.mode = MODE_ESC;
					end else begin
						emit  = 1'b1;
						value = in_byte;
					end
				end
				MODE_ESC: begin
					nxt.mode = MODE_TEXT;
					emit     = 1'b1;
					case (in_byte)
						CH_ZERO: value = CH_NUL;
						CH_A:    value = CTL_BEL;
						CH_B:    value = CTL_BS;
						CH_F:    value = CTL_FF;
						CH_N:    value = CTL_LF;
						CH_R:    value = CTL_CR;
						CH_T:    value = CTL_HT;
						CH_V:    value = CTL_VT;
						CH_X: begin
							emit     = 1'b0;
							nxt.mode = MODE_HEX1;
						end
						default: begin
							if (is_alnum(in_byte)) begin
								emit    = 1'b0;
								nxt.err = 1'b1;
							end else begin
								value = in_byte;
							end
						end
					endcase
				end
				MODE_HEX1: begin
					if (hex[4]) begin
						nxt.err = 1'b1;
					end else begin
						nxt.nibble = hex[3:0];
						nxt.mode   = MODE_HEX2;
					end
				end
				MODE_HEX2: begin
					if (hex[4]) begin
						nxt.err = 1'b1;
					end else begin
						emit     = 1'b1;
						value    = {cur.nibble, hex[3:0]};
						nxt.mode = MODE_TEXT;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
		// A string that stops in the middle of an escape is malformed.
		if ((last || zero) && nxt.mode != MODE_TEXT) nxt.err = 1'b1;
	end

	always_comb begin
		res.emit   = emit;
		res.value  = value;
		res.ending = last || zero;
		res.err    = nxt.err;
	end

endmodule

/* rtl/c_escape_unescaper.sv */
// ---------------------------------------------------------------------------
// C escape unescaper
// Streaming decoder for C-style string escapes, one source byte per cycle while results are taken.
// ---------------------------------------------------------------------------
//
//  Channel  | Dir | tdata (low bit up)                    | tuser    | tlast
//  ---------+-----+---------------------------------------+----------+--------------
//  s_axis   | in  | in_byte[7:0]                          | -        | last
//  m_axis   | out | out_byte[7:0], status, out_length[12:0]| has_byte | end_of_string
//
// Each source byte passes through an input register and one pass of decode
// logic into a result register, and a new byte is taken every cycle while
// results are taken. Bytes that yield nothing (a backslash, the first digits
// of a hex escape, anything after an error) free their slot without using
// the result register. When the result register is full and not taken, the
// input register holds, and s_axis_tready drops once it is also occupied.
// Reset clears all decode state; the first string starts in plain text mode.
// ---------------------------------------------------------------------------
`include "c_escape_unescaper_defines.svh"

module c_escape_unescaper #(
	parameter int unsigned MAX_LENGTH = cesc_pkg::MAX_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [8] status,
	                                   // [21:9] out_length, [23:22] zero
	output logic        m_axis_tuser,  // [0] has_byte
	output logic        m_axis_tlast   // end_of_string
);
	import cesc_pkg::*;

	// The count must reach MAX_LENGTH itself before it saturates.
	localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Decode state, held across the bytes of one string.
	dec_state_t        st_q;
	logic [CNT_W-1:0]  cnt_q;

	// Result register stage.
	logic              valid_s2;
	logic              has_byte_s2;
	logic [7:0]        out_byte_s2;
	logic              eos_s2;
	logic              status_s2;
	logic [LEN_W-1:0]  len_s2;

	dec_state_t        st_nxt;
	dec_result_t       res;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [LEN_W-1:0]  len_nxt;
	logic              s2_free;
	logic              advance;
	logic              produce;
	logic              s_xfer;

	cesc_decode u_decode (
		.in_byte (byte_s1),
		.last    (last_s1),
		.cur     (st_q),
		.nxt     (st_nxt),
		.res     (res)
	);

	// The result register can take a new result when empty or being drained.
	// Stage 1 only moves on when that is so, which keeps results in order.
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && s2_free;
	assign produce       = res.emit || res.ending;
	assign s_axis_tready = !valid_s1 || s2_free;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	// The byte count saturates at MAX_LENGTH; the reported length keeps its low bits.
	always_comb begin
		cnt_nxt = cnt_q;
		if (res.emit && cnt_q < CNT_W'(MAX_LENGTH)) cnt_nxt = cnt_q + 1'b1;
		len_nxt = LEN_W'(cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Decode state advances with each byte; the end of a string resets it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RESET;
			cnt_q <= '0;
		end else if (advance) begin
			if (res.ending) begin
				st_q  <= STATE_RESET;
				cnt_q <= '0;
			end else begin
				st_q  <= st_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && produce) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Status and length are only meaningful on the closing result and read zero
	// otherwise; the output byte reads zero when no byte is carried.
	always_ff @(posedge clk) begin
		if (advance && produce) begin
			has_byte_s2 <= res.emit;
			out_byte_s2 <= res.emit ? res.value : '0;
			eos_s2      <= res.ending;
			status_s2   <= res.ending ? res.err : 1'b0;
			len_s2      <= res.ending ? len_nxt : '0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = has_byte_s2;
	assign m_axis_tlast  = eos_s2;
	assign m_axis_tdata  = {2'b00, len_s2, status_s2, out_byte_s2};

	// A result that neither carries a byte nor closes a string must never appear.
	`CESC_ASSERT_IMP(a_result_has_content, valid_s2, has_byte_s2 || eos_s2,
		"result carries neither a byte nor an end of string")
	// Status and length stay zero on results inside a string.
	`CESC_ASSERT_IMP(a_mid_string_zero, valid_s2 && !eos_s2,
		!status_s2 && len_s2 == '0, "status or length set before end of string")
	// The output byte is zero when no byte is carried.
	`CESC_ASSERT_IMP(a_empty_byte_zero, valid_s2 && !has_byte_s2,
		out_byte_s2 == '0, "output byte nonzero without a decoded byte")
	// Closing a string leaves the decoder in its reset state for the next one.
	`CESC_ASSERT_NEXT(a_end_resets_state, advance && res.ending,
		st_q.mode == MODE_TEXT && !st_q.err && cnt_q == '0,
		"decode state not cleared after end of string")

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// C escape unescaper testbench
// Streams strings into the decoder through s_axis and checks every m_axis
// transfer against an in-bench decoder model, with random gaps on both sides,
// long receiver hold-offs and sender pauses that let the decoder drain.
// ---------------------------------------------------------------------------
module tb;
	import cesc_pkg::*;

	localparam int unsigned LEN_CAP       = MAX_LENGTH_DEF;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned HOLD_CYCLES   = 160;
	localparam int unsigned HOLD_SPACING  = 900;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [7:0]  CH_Q          = 8'h71;

	// One source byte waiting to be sent. A set pause flag makes the sender wait
	// until every expected result has arrived before offering this byte.
	typedef struct {
		logic [7:0] chr;
		logic       last;
		logic       pause;
	} src_item_t;

	// One decoded result as the block should deliver it.
	typedef struct {
		logic        has;
		logic [7:0]  chr;
		logic        eos;
		logic        bad;
		logic [12:0] len;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
	logic        s_axis_tlast  = 1'b0;   // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // [7:0] out_byte, [8] status, [21:9] out_length
	logic        m_axis_tuser;           // [0] has_byte
	logic        m_axis_tlast;           // end_of_string

	src_item_t   src_q [$];
	decoded_t    decoded_q [$];
	int          errors = 0;
	int unsigned owed;
	int unsigned bytes_in;
	int unsigned sent_cnt;
	int unsigned got_cnt;
	logic [3:0]  send_gap;
	logic [3:0]  take_wait;
	logic [7:0]  hold_left;
	int unsigned next_hold;
	int unsigned stall_cycles;
	logic        hold_on;

	// Decoder model state.
	mode_t       dec_mode  = MODE_TEXT;
	logic [3:0]  dec_nib   = 4'd0;
	logic        dec_err   = 1'b0;
	logic [12:0] dec_count = 13'd0;

	c_escape_unescaper #(.MAX_LENGTH(LEN_CAP)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// ---------------------------------------------------------------------
	// Character helpers
	// ---------------------------------------------------------------------
	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LZ) ||
			(c >= CH_UA && c <= CH_UZ);
	endfunction

	// Returns 1 and the digit value when c is a hex digit in either case.
	function automatic logic hex_ok(input logic [7:0] c, output logic [3:0] nib);
		nib = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			nib = 4'(c - CH_ZERO);
			return 1'b1;
		end
		if (c >= CH_LA && c <= CH_LF) begin
			nib = 4'(c - CH_LA + 8'd10);
			return 1'b1;
		end
		if (c >= CH_UA && c <= CH_UF) begin
			nib = 4'(c - CH_UA + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_glyph(input logic [3:0] nib, input logic upper);
		if (nib < 4'd10)
			return CH_ZERO + 8'(nib);
		return (upper ? CH_UA : CH_LA) + 8'(nib) - 8'd10;
	endfunction

	// The eight characters that name a single-character escape.
	function automatic logic [7:0] esc_letter(input int unsigned i);
		case (i)
			0: return CH_ZERO;
			1: return CH_A;
			2: return CH_B;
			3: return CH_F;
			4: return CH_N;
			5: return CH_R;
			6: return CH_T;
			default: return CH_V;
		endcase
	endfunction

	function automatic logic calm_stretch(input int unsigned n);
		return ((n / 64) % 4) == 3;
	endfunction

	// ---------------------------------------------------------------------
	// Decoder model: advances the model state by one accepted byte and queues
	// the result it causes, if any.
	// ---------------------------------------------------------------------
	function automatic void predict_byte(input logic [7:0] b, input logic lst);
		decoded_t   r;
		logic       emit;
		logic [7:0] val;
		logic [3:0] nib;
		emit = 1'b0;
		val  = 8'h00;
		if (b == CH_NUL) begin
			// A zero byte only ends the string; inside an escape it is an error.
			if (dec_mode != MODE_TEXT)
				dec_err = 1'b1;
		end else if (!dec_err) begin
			case (dec_mode)
				MODE_TEXT: begin
					if (b == CH_BSLASH) begin
						dec_mode = MODE_ESC;
					end else begin
						emit = 1'b1;
						val  = b;
					end
				end
				MODE_ESC: begin
					dec_mode = MODE_TEXT;
					emit     = 1'b1;
					case (b)
						CH_ZERO: val = 8'h00;
						CH_A:    val = CTL_BEL;
						CH_B:    val = CTL_BS;
						CH_F:    val = CTL_FF;
						CH_N:    val = CTL_LF;
						CH_R:    val = CTL_CR;
						CH_T:    val = CTL_HT;
						CH_V:    val = CTL_VT;
						CH_X: begin
							emit     = 1'b0;
							dec_mode = MODE_HEX1;
						end
						default: begin
							// Unknown letters and digits are malformed; anything else
							// (punctuation, high bytes) stands for itself.
							if (is_word_char(b)) begin
								emit    = 1'b0;
								dec_err = 1'b1;
							end else begin
								val = b;
							end
						end
					endcase
				end
				MODE_HEX1: begin
					if (hex_ok(b, nib)) begin
						dec_nib  = nib;
						dec_mode = MODE_HEX2;
					end else begin
						dec_err = 1'b1;
					end
				end
				default: begin
					if (hex_ok(b, nib)) begin
						emit     = 1'b1;
						val      = {dec_nib, nib};
						dec_mode = MODE_TEXT;
					end else begin
						dec_err = 1'b1;
					end
				end
			endcase
		end

		if (emit && dec_count < LEN_CAP)
			dec_count = dec_count + 13'd1;

		if (lst || b == CH_NUL) begin
			// An escape still open at the end of the string is malformed.
			if (dec_mode != MODE_TEXT)
				dec_err = 1'b1;
			r = '{emit, val, 1'b1, dec_err, dec_count};
			decoded_q.push_back(r);
			dec_mode  = MODE_TEXT;
			dec_nib   = 4'd0;
			dec_err   = 1'b0;
			dec_count = 13'd0;
		end else if (emit) begin
			r = '{1'b1, val, 1'b0, 1'b0, 13'd0};
			decoded_q.push_back(r);
		end
	endfunction

	function automatic void check_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", fname, want, got);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------------
	task automatic push_src(input logic [7:0] c, input logic lst);
		src_item_t it;
		it = '{c, lst, 1'b0};
		src_q.push_back(it);
	endtask

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		logic [3:0] nib;
		do
			c = 8'($urandom_range(1, 255));
		while (hex_ok(c, nib));
		return c;
	endfunction

	// One piece of a string. Clean pieces each decode to exactly one byte;
	// the rest are malformed escapes, random bytes after a backslash, or an
	// escape cut off by a zero byte.
	task automatic add_token(input logic clean);
		int unsigned kind;
		logic [7:0]  c;
		kind = clean ? $urandom_range(0, 84) : $urandom_range(0, 99);
		if (kind < 40) begin
			do
				c = 8'($urandom_range(1, 255));
			while (c == CH_BSLASH);
			push_src(c, 1'b0);
		end else if (kind < 60) begin
			push_src(CH_BSLASH, 1'b0);
			push_src(esc_letter($urandom_range(0, 7)), 1'b0);
		end else if (kind < 75) begin
			push_src(CH_BSLASH, 1'b0);
			push_src(CH_X, 1'b0);
			push_src(hex_glyph(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
			push_src(hex_glyph(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
		end else if (kind < 85) begin
			do
				c = 8'($urandom_range(1, 255));
			while (is_word_char(c));
			push_src(CH_BSLASH, 1'b0);
			push_src(c, 1'b0);
		end else begin
			push_src(CH_BSLASH, 1'b0);
			case ($urandom_range(0, 4))
				0: begin
					do
						c = 8'($urandom_range(1, 255));
					while (!is_word_char(c) ||
						c inside {CH_ZERO, CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V, CH_X});
					push_src(c, 1'b0);
				end
				1: begin
					push_src(CH_X, 1'b0);
					push_src(non_hex_byte(), 1'b0);
				end
				2: begin
					push_src(CH_X, 1'b0);
					push_src(hex_glyph(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
					push_src(non_hex_byte(), 1'b0);
				end
				3: push_src(8'($urandom_range(0, 255)), 1'b0);
				default: begin
					if ($urandom_range(0, 1))
						push_src(CH_X, 1'b0);
					push_src(CH_NUL, 1'b0);
				end
			endcase
		end
	endtask

	// A string of random pieces, closed by the last flag on its final byte, by a
	// zero byte (with or without last), or cut short inside an escape.
	task automatic add_random_string(input logic pause_first, input logic clean);
		int unsigned first;
		int unsigned pieces;
		first  = src_q.size();
		pieces = $urandom_range(1, 10);
		repeat (pieces)
			add_token(clean);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: src_q[src_q.size() - 1].last = 1'b1;
			6, 7: push_src(CH_NUL, 1'b0);
			8: push_src(CH_NUL, 1'b1);
			default: begin
				push_src(CH_BSLASH, $urandom_range(0, 2) == 0);
				if (!src_q[src_q.size() - 1].last) begin
					push_src(CH_X, 1'($urandom_range(0, 1)));
					if (!src_q[src_q.size() - 1].last)
						push_src(hex_glyph(4'($urandom_range(0, 15)), 1'b0), 1'b1);
				end
			end
		endcase
		src_q[first].pause = pause_first;
	endtask

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Sender: offers queued bytes with a random gap before each one.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : send_proc
		src_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
			send_gap      <= 4'd0;
			sent_cnt      <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap != 4'd0) begin
				s_axis_tvalid <= 1'b0;
				send_gap      <= send_gap - 4'd1;
			end else if (src_q.size() != 0 &&
				(!src_q[0].pause || (!s_axis_tvalid && owed == 0))) begin
				nxt = src_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= nxt.chr;
				s_axis_tlast  <= nxt.last;
				send_gap      <= calm_stretch(sent_cnt) ? 4'd0 : 4'($urandom_range(0, 13));
				sent_cnt      <= sent_cnt + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver hold-off: after 300 accepted bytes and every HOLD_SPACING bytes
	// more, the receiver takes no results for a HOLD_CYCLES countdown, so the decoder backs up.
	// ---------------------------------------------------------------------
	assign hold_on = (hold_left != 8'd0);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 8'd0;
			next_hold <= 300;
		end else if (hold_left != 8'd0) begin
			hold_left <= hold_left - 8'd1;
		end else if (bytes_in >= next_hold) begin
			hold_left <= 8'(HOLD_CYCLES);
			next_hold <= next_hold + HOLD_SPACING;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: predicts on every s_axis transfer, checks every m_axis transfer
	// against the oldest expectation, and draws the receiver's stalls.
	// Prediction comes first so a same-edge result would still find its entry.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : observe_proc
		decoded_t   want;
		logic [3:0] wait_next;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			take_wait     <= 4'd0;
			owed          <= 0;
			bytes_in      <= 0;
			got_cnt       <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_byte(s_axis_tdata, s_axis_tlast);
				bytes_in <= bytes_in + 1;
			end
			wait_next = (take_wait != 4'd0) ? take_wait - 4'd1 : 4'd0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					$error("result transfer with nothing expected: tdata %h tuser %b tlast %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					check_field("has_byte", want.has, m_axis_tuser);
					check_field("out_byte", want.chr, m_axis_tdata[7:0]);
					check_field("end_of_string", want.eos, m_axis_tlast);
					check_field("status", want.bad, m_axis_tdata[8]);
					check_field("out_length", want.len, m_axis_tdata[21:9]);
				end
				wait_next = calm_stretch(got_cnt) ? 4'd0 : 4'($urandom_range(0, 13));
				got_cnt <= got_cnt + 1;
			end
			take_wait     <= wait_next;
			m_axis_tready <= !hold_on && wait_next == 4'd0;
			owed          <= decoded_q.size();
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: too long without any transfer on either side ends the run.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL c_escape_unescaper");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and run control
	// ---------------------------------------------------------------------
	initial begin
		int unsigned strings;
		arst_n = 1'b0;

		// Directed strings. An empty string closed by a zero byte that also
		// carries last, then the top byte value finishing a string on its own.
		push_src(CH_NUL, 1'b1);
		push_src(8'hFF, 1'b1);
		// Every single-letter escape, closed by a zero byte.
		for (int i = 0; i < 8; i++) begin
			push_src(CH_BSLASH, 1'b0);
			push_src(esc_letter(i), 1'b0);
		end
		push_src(CH_NUL, 1'b0);
		// Mixed-case hex escape whose last digit also closes the string.
		push_src(CH_BSLASH, 1'b0);
		push_src(CH_X, 1'b0);
		push_src(CH_LA, 1'b0);
		push_src(CH_UF, 1'b1);
		// Unknown letter escape; the byte after it is dropped.
		push_src(CH_BSLASH, 1'b0);
		push_src(CH_Q, 1'b0);
		push_src(CH_LZ, 1'b1);
		// Lone backslash at the end of a string.
		push_src(CH_BSLASH, 1'b1);
		// Hex escape cut off by a zero byte.
		push_src(CH_BSLASH, 1'b0);
		push_src(CH_X, 1'b0);
		push_src(CH_NUL, 1'b0);

		// Random strings, mostly well formed; every 40th waits for the decoder
		// to drain first.
		strings = 0;
		while (src_q.size() < 1800) begin
			add_random_string(strings % 40 == 39, $urandom_range(0, 3) == 0);
			strings++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (src_q.size() != 0 || s_axis_tvalid || owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (decoded_q.size() != 0) begin
			$error("%0d expected results never arrived", decoded_q.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS c_escape_unescaper");
		else
			$display("FAIL c_escape_unescaper");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/cesc_pkg.sv
rtl/cesc_decode.sv
rtl/c_escape_unescaper.sv
tb/sv/tb.sv
